### hdl/cbz_pkg.sv
// Shared constants for the cubic Bezier point evaluator.
package cbz_pkg;

    localparam int COORD_W         = 10;
    localparam int NUM_REGS        = 8;
    localparam int REG_IDX_W       = 3;
    localparam int CFG_IDX_W       = 4;

    localparam int DEF_NUM_POINTS  = 4;
    localparam int DEF_T_FRAC_BITS = 16;

    // Axis codes inside the point arrays; register index is 2 * point + axis.
    localparam int AX_X            = 0;
    localparam int AX_Y            = 1;
    localparam int NUM_AXES        = 2;

    // Register indexes of the first control point.
    localparam int REG_P0_X        = 0;
    localparam int REG_P0_Y        = 1;

endpackage

### hdl/cubic_bezier_point_eval.sv
// Cubic Bezier point evaluator: de Casteljau lerp pipeline with control-point registers.
// Throughput: one beat per cycle unless the output stalls.
// Each lerp level is a multiply stage then a round/add stage.
// Stalls back up stage by stage, so empty stages still take a new beat while a result waits.
// Reset (i_rst_n low at a clock edge) empties the pipeline and clears all control points.
module cubic_bezier_point_eval #(
    parameter int NUM_POINTS  = cbz_pkg::DEF_NUM_POINTS,
    parameter int T_FRAC_BITS = cbz_pkg::DEF_T_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cbz_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cbz_pkg::COORD_W-1:0]   i_cfg_data,
    // parameter input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [T_FRAC_BITS:0]          i_param_t,
    // curve point output channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [cbz_pkg::COORD_W-1:0]   o_curve_x,
    output logic [cbz_pkg::COORD_W-1:0]   o_curve_y
);
    import cbz_pkg::*;

    // Geometry of the pipeline and its datapath.
    localparam int NL     = NUM_POINTS - 1;        // lerp levels
    localparam int NSTG   = 1 + 2 * NL;            // t stage, then mult/add per level
    localparam int TW     = T_FRAC_BITS + 1;       // saturated t, 0 .. 1.0
    localparam int W      = COORD_W + T_FRAC_BITS; // unsigned Q10.F coordinate
    localparam int DW     = W + 1;                 // signed difference b - a
    localparam int MW     = DW + TW + 1;           // signed product
    localparam int LAST_X = 2 * (NUM_POINTS - 1);  // register of last point x

    localparam logic [TW-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};
    localparam logic signed [MW-1:0] RND_HALF =
        {{(MW - T_FRAC_BITS){1'b0}}, 1'b1, {(T_FRAC_BITS - 1){1'b0}}};

    // ------------------------------------------------------------------
    // Control-point registers. Writes beyond the register list drop.
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] r_cfg [NUM_REGS];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                r_cfg[k] <= '0;
            end
        end else if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(NUM_REGS))) begin
            r_cfg[i_cfg_index[REG_IDX_W-1:0]] <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake: a stage loads when it is empty or its contents
    // move on in the same cycle. Valid bits travel with the data.
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] stg_ld;

    always_comb begin
        stg_ld[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;
        for (int s = NSTG - 2; s >= 0; s--) begin
            stg_ld[s] = !r_vld[s] || stg_ld[s+1];
        end
    end

    assign n_vld      = {r_vld[NSTG-2:0], i_in_valid};
    assign o_in_ready = stg_ld[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < NSTG; s++) begin
                if (stg_ld[s]) begin
                    r_vld[s] <= n_vld[s];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: saturate t to 1.0.
    // ------------------------------------------------------------------
    logic [TW-1:0] r_t0;

    always_ff @(posedge i_clk) begin
        if (stg_ld[0] && i_in_valid) begin
            r_t0 <= (i_param_t > T_ONE) ? T_ONE : i_param_t;
        end
    end

    // ------------------------------------------------------------------
    // Lerp levels. Every level lerps all neighbor pairs and passes the top
    // point through; entry i after level l depends only on points i..i+l+1,
    // so entry 0 of the last level is the curve point.
    // ------------------------------------------------------------------
    logic [W-1:0]           r_m_pt   [NL][NUM_AXES][NUM_POINTS];
    logic signed [MW-1:0]   r_m_prod [NL][NUM_AXES][NUM_POINTS-1];
    logic [TW-1:0]          r_m_t    [NL];
    logic [W-1:0]           r_p_pt   [NL][NUM_AXES][NUM_POINTS];
    logic [TW-1:0]          r_p_t    [NL];

    for (genvar l = 0; l < NL; l++) begin : g_lvl
        logic [W-1:0]         lv_pt   [NUM_AXES][NUM_POINTS];
        logic [TW-1:0]        lv_t;
        logic signed [DW-1:0] lv_diff [NUM_AXES][NUM_POINTS-1];
        logic signed [MW-1:0] lv_prod [NUM_AXES][NUM_POINTS-1];
        logic signed [MW-1:0] lv_step [NUM_AXES][NUM_POINTS-1];
        logic [W-1:0]         lv_new  [NUM_AXES][NUM_POINTS-1];

        // Level inputs: control points widened to Q10.F, or the level below.
        if (l == 0) begin : g_src
            always_comb begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    for (int i = 0; i < NUM_POINTS; i++) begin
                        lv_pt[a][i] = {r_cfg[REG_IDX_W'(2 * i + a)], {T_FRAC_BITS{1'b0}}};
                    end
                end
                lv_t = r_t0;
            end
        end else begin : g_chain
            always_comb begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    for (int i = 0; i < NUM_POINTS; i++) begin
                        lv_pt[a][i] = r_p_pt[l-1][a][i];
                    end
                end
                lv_t = r_p_t[l-1];
            end
        end

        // Multiply stage: (b - a) * t.
        always_comb begin
            for (int a = 0; a < NUM_AXES; a++) begin
                for (int i = 0; i < NUM_POINTS - 1; i++) begin
                    lv_diff[a][i] = $signed({1'b0, lv_pt[a][i+1]}) - $signed({1'b0, lv_pt[a][i]});
                    lv_prod[a][i] = lv_diff[a][i] * $signed({1'b0, lv_t});
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (stg_ld[1+2*l] && n_vld[1+2*l]) begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    for (int i = 0; i < NUM_POINTS; i++) begin
                        r_m_pt[l][a][i] <= lv_pt[a][i];
                    end
                    for (int i = 0; i < NUM_POINTS - 1; i++) begin
                        r_m_prod[l][a][i] <= lv_prod[a][i];
                    end
                end
                r_m_t[l] <= lv_t;
            end
        end

        // Add stage: round half up, then add to a. The sum is known to lie
        // between a and b, so a W-bit wrapping add is exact.
        always_comb begin
            for (int a = 0; a < NUM_AXES; a++) begin
                for (int i = 0; i < NUM_POINTS - 1; i++) begin
                    lv_step[a][i] = (r_m_prod[l][a][i] + RND_HALF) >>> T_FRAC_BITS;
                    lv_new[a][i]  = r_m_pt[l][a][i] + lv_step[a][i][W-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (stg_ld[2+2*l] && n_vld[2+2*l]) begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    for (int i = 0; i < NUM_POINTS - 1; i++) begin
                        r_p_pt[l][a][i] <= lv_new[a][i];
                    end
                    r_p_pt[l][a][NUM_POINTS-1] <= r_m_pt[l][a][NUM_POINTS-1];
                end
                r_p_t[l] <= r_m_t[l];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result: truncate the last level's point to whole pixels.
    // ------------------------------------------------------------------
    assign o_out_valid = r_vld[NSTG-1];
    assign o_curve_x   = r_p_pt[NL-1][AX_X][0][W-1:T_FRAC_BITS];
    assign o_curve_y   = r_p_pt[NL-1][AX_Y][0][W-1:T_FRAC_BITS];

`ifndef SYNTHESIS
    // An empty pipeline must take a beat.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld == '0) |-> o_in_ready)
        else $error("empty pipeline refuses input");

    // An accepted beat lands in the first stage.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted beat lost at first stage");

    // Saturation holds all the way down the pipeline.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NSTG-1] |-> (r_p_t[NL-1] <= T_ONE))
        else $error("t above one reached the output");

    // t of zero gives the first control point.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTG-1] && (r_p_t[NL-1] == '0)) |->
        ((o_curve_x == r_cfg[REG_P0_X]) && (o_curve_y == r_cfg[REG_P0_Y])))
        else $error("t of zero does not give the first point");

    // t of one gives the last control point.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTG-1] && (r_p_t[NL-1] == T_ONE)) |->
        ((o_curve_x == r_cfg[LAST_X]) && (o_curve_y == r_cfg[LAST_X+1])))
        else $error("t of one does not give the last point");
`endif

endmodule
